### rtl/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared constants and types of the 3x3 median filter: pixel and window
// types, line store word and write port, median request.
// ----------------------------------------------------------------------------
`default_nettype none

package mf3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int PIXEL_BITS = 8;
    localparam int WIN_SIZE   = 9;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = 11;
    localparam int HGT_W      = 12;
    localparam int ROW_W      = HGT_W + 1;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [WID_W-1:0] MIN_WIDTH    = WID_W'(3);
    localparam logic [WID_W-1:0] CAP_WIDTH    = WID_W'(MAX_WIDTH);
    localparam logic [WID_W-1:0] RESET_WIDTH  = WID_W'(640);
    localparam logic [HGT_W-1:0] RESET_HEIGHT = HGT_W'(480);

    // register index, taken from paddr[2]
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIXEL_BITS-1:0] t_pix;
    // index = row*3 + col, col 0 leftmost
    typedef logic [WIN_SIZE-1:0][PIXEL_BITS-1:0] t_win;

    typedef struct packed {
        t_pix upper;
        t_pix middle;
    } t_ls_word;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        t_ls_word         data;
    } t_ls_wr;

    typedef struct packed {
        logic valid;
        logic last;
        t_win win;
    } t_med_req;

endpackage

`default_nettype wire

### rtl/mf3_line_store.sv
// ----------------------------------------------------------------------------
// mf3_line_store
// The two previous lines, one entry per column holding the upper and middle
// pixel. Synchronous read with registered data, one write port, and bypass
// of a write that lands on the entry read at the same edge.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_line_store (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_rd_en,
    input  wire logic [mf3_pkg::COL_W-1:0] i_rd_addr,
    output      mf3_pkg::t_ls_word     o_rd_data,
    input  wire mf3_pkg::t_ls_wr       i_wr
);
    import mf3_pkg::*;

    t_ls_word r_mem [MAX_WIDTH];
    t_ls_word r_q;
    t_ls_word r_fwd_data;
    logic     r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr.en && (i_wr.addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_q;

    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rd_en && i_wr.en && (i_wr.addr == i_rd_addr)) |=> (o_rd_data == $past(i_wr.data)))
        else $error("line store bypass lost a same-entry write");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rd_en |=> $stable(o_rd_data))
        else $error("line store read data moved without a read");

endmodule

`default_nettype wire

### rtl/mf3_median.sv
// ----------------------------------------------------------------------------
// mf3_median
// Three-stage median-of-nine network: sort rows, then max of the row minima,
// median of the row medians and min of the row maxima, then median of those
// three. The last stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_median (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mf3_pkg::t_med_req i_req,
    output      logic              o_ready,
    output      logic              o_valid,
    output      mf3_pkg::t_pix     o_median,
    output      logic              o_last,
    input  wire logic              i_ready
);
    import mf3_pkg::*;

    function automatic t_pix f_min(input t_pix a, input t_pix b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_pix f_max(input t_pix a, input t_pix b);
        return (a < b) ? b : a;
    endfunction

    function automatic t_pix f_med3(input t_pix a, input t_pix b, input t_pix c);
        return f_max(f_min(a, b), f_min(f_max(a, b), c));
    endfunction

    logic en1, en2, en3;
    logic r_v1, r_v2, r_v3;
    logic r_l1, r_l2, r_l3;
    t_pix r_lo  [3];
    t_pix r_mi  [3];
    t_pix r_hi  [3];
    t_pix r_a, r_b, r_c;
    t_pix r_med;

    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_req.valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // sort each window row
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_l1 <= i_req.last;
            for (int k = 0; k < 3; k++) begin
                r_lo[k] <= f_min(f_min(i_req.win[3*k], i_req.win[3*k+1]), i_req.win[3*k+2]);
                r_mi[k] <= f_med3(i_req.win[3*k], i_req.win[3*k+1], i_req.win[3*k+2]);
                r_hi[k] <= f_max(f_max(i_req.win[3*k], i_req.win[3*k+1]), i_req.win[3*k+2]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_l2 <= r_l1;
            r_a  <= f_max(f_max(r_lo[0], r_lo[1]), r_lo[2]);
            r_b  <= f_med3(r_mi[0], r_mi[1], r_mi[2]);
            r_c  <= f_min(f_min(r_hi[0], r_hi[1]), r_hi[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_l3  <= r_l2;
            r_med <= f_med3(r_a, r_b, r_c);
        end
    end

    assign o_valid  = r_v3;
    assign o_median = r_med;
    assign o_last   = r_l3;

endmodule

`default_nettype wire

### rtl/median_filter_3x3_unit.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_unit
// Streaming 3x3 median filter with zero padding, raster order, line stores
// in one synchronous memory read-modified-written once per item.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_axis    in         tdata[7:0] pixel, tuser[0] flush
//  m_axis    out        tdata[7:0] median, tlast frame_end
//  apb       in/out     0x0 frame_width[10:0], 0x4 frame_height[11:0]
//
//  One item per clock while m_axis takes results; an accepted item waits in
//  the read stage, then passes row sort with window update, row combine and
//  final median into the output register. The line store read is issued on
//  acceptance. The rate is set by the single line store read-modify-write
//  per item. Reset clears counters and window; the line store is not cleared,
//  rows above the frame are masked by the row count. Back pressure on m_axis
//  fills the median pipeline bubbles first, then drops s_axis tready.
// ----------------------------------------------------------------------------
`default_nettype none

module median_filter_3x3_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_axis_tvalid,
    output      logic                        o_s_axis_tready,
    input  wire logic [7:0]                  i_s_axis_tdata,  // [7:0] pixel
    input  wire logic                        i_s_axis_tuser,  // [0] flush
    output      logic                        o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    output      logic [7:0]                  o_m_axis_tdata,  // [7:0] median
    output      logic                        o_m_axis_tlast,  // frame_end
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mf3_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [mf3_pkg::APB_DATA_W-1:0] pwdata,
    output      logic [mf3_pkg::APB_DATA_W-1:0] prdata,
    output      logic                        pready
);
    import mf3_pkg::*;

    // configuration
    logic [WID_W-1:0] r_cfg_width;
    logic [HGT_W-1:0] r_cfg_height;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RESET_WIDTH;
            r_cfg_height <= RESET_HEIGHT;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_FRAME_WIDTH:  r_cfg_width  <= pwdata[WID_W-1:0];
                REG_FRAME_HEIGHT: r_cfg_height <= pwdata[HGT_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(r_cfg_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(r_cfg_height);
        endcase
    end

    // position counters, evaluated for the item being accepted
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [WID_W-1:0] w_eff;
    logic [HGT_W-1:0] h_eff;
    logic             wrap_pre;
    logic [COL_W-1:0] a_col;
    logic [ROW_W-1:0] a_row;
    logic [WID_W-1:0] a_col_inc;
    t_pix             a_pix;
    logic             a_emit, a_last;
    logic             acc;

    always_comb begin
        priority if (r_cfg_width < MIN_WIDTH) begin
            w_eff = MIN_WIDTH;
        end else if (r_cfg_width > CAP_WIDTH) begin
            w_eff = CAP_WIDTH;
        end else begin
            w_eff = r_cfg_width;
        end
        h_eff = (r_cfg_height == '0) ? HGT_W'(1) : r_cfg_height;

        // wrap first if the width shrank under the column count
        wrap_pre = WID_W'(r_col) >= w_eff;
        a_col    = wrap_pre ? '0 : r_col;
        a_row    = wrap_pre ? r_row + ROW_W'(1) : r_row;

        a_pix  = (i_s_axis_tuser || (a_row >= ROW_W'(h_eff))) ? '0 : t_pix'(i_s_axis_tdata);
        a_emit = (a_row >= ROW_W'(2)) || ((a_row == ROW_W'(1)) && (a_col != '0));
        a_last = (a_row >= ROW_W'(h_eff) + ROW_W'(1)) && (a_col == '0);

        a_col_inc = WID_W'(a_col) + WID_W'(1);
        priority if (a_last) begin
            n_col = '0;
            n_row = '0;
        end else if (a_col_inc >= w_eff) begin
            n_col = '0;
            n_row = a_row + ROW_W'(1);
        end else begin
            n_col = a_col_inc[COL_W-1:0];
            n_row = a_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // read stage: item waits here for its line store entry
    logic             r_b_valid;
    logic [COL_W-1:0] r_b_col;
    t_pix             r_b_pix;
    logic             r_b_top_en, r_b_mid_en, r_b_emit, r_b_last;
    logic             med_ready;
    logic             step;

    assign step            = r_b_valid && med_ready;
    assign o_s_axis_tready = !r_b_valid || med_ready;
    assign acc             = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (acc) begin
            r_b_valid <= 1'b1;
        end else if (step) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_b_col    <= a_col;
            r_b_pix    <= a_pix;
            r_b_top_en <= a_row >= ROW_W'(2);
            r_b_mid_en <= a_row != '0;
            r_b_emit   <= a_emit;
            r_b_last   <= a_last;
        end
    end

    // line store: shift the column down one line on the way out
    t_ls_word ls_rd;
    t_ls_wr   ls_wr;

    always_comb begin
        ls_wr.en          = step;
        ls_wr.addr        = r_b_col;
        ls_wr.data.upper  = ls_rd.middle;
        ls_wr.data.middle = r_b_pix;
    end

    mf3_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (acc),
        .i_rd_addr (a_col),
        .o_rd_data (ls_rd),
        .i_wr      (ls_wr)
    );

    // window
    t_win     r_win, n_win, shown;
    t_pix     new_col [3];
    logic     b_c0;
    t_med_req med_req;

    always_comb begin
        b_c0       = r_b_col == '0;
        new_col[0] = r_b_top_en ? ls_rd.upper  : '0;
        new_col[1] = r_b_mid_en ? ls_rd.middle : '0;
        new_col[2] = r_b_pix;
        for (int k = 0; k < 3; k++) begin
            // at line start the previous line's last column is shown, right side zero
            shown[3*k]   = r_win[3*k+1];
            shown[3*k+1] = r_win[3*k+2];
            shown[3*k+2] = b_c0 ? '0 : new_col[k];
            n_win[3*k]   = b_c0 ? '0 : r_win[3*k+1];
            n_win[3*k+1] = b_c0 ? '0 : r_win[3*k+2];
            n_win[3*k+2] = new_col[k];
        end
        med_req.valid = step && r_b_emit;
        med_req.last  = r_b_last;
        med_req.win   = shown;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (step) begin
            r_win <= n_win;
        end
    end

    mf3_median u_median (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (med_req),
        .o_ready  (med_ready),
        .o_valid  (o_m_axis_tvalid),
        .o_median (o_m_axis_tdata),
        .o_last   (o_m_axis_tlast),
        .i_ready  (i_m_axis_tready)
    );

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && a_last) |=> ((r_col == '0) && (r_row == '0)))
        else $error("counters not cleared after the frame's last item");

    a_read_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !step) |=> (r_b_valid && $stable(r_b_col) && $stable(r_b_pix)))
        else $error("read stage item lost while stalled");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= ROW_W'(1 << HGT_W))
        else $error("row count ran past the frame");

endmodule

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming 3x3 median filter. Frames of pixels
// followed by their flush items go in over the stream input, frame sizes are
// set over the register port between frames, and every median coming out is
// compared with a bit-accurate model of the line stores and window kept here.
// Both stream sides idle at random; one frame runs against a long output stall.
// ----------------------------------------------------------------------------
module tb;
    import mf3_pkg::*;

    localparam int     CLK_HALF      = 10;
    localparam int     RESET_CYCLES  = 8;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     MAX_GAP       = 8;
    localparam int     LONG_HOLD     = 300;
    localparam int     RANDOM_ITEMS  = 500;
    localparam longint RUN_LIMIT     = 64'd60_000_000;

    typedef struct packed {
        t_pix median;
        logic frame_end;
    } t_median_exp;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_valid;
    logic                  s_ready;
    t_pix                  s_data;
    logic                  s_flush;
    logic                  m_valid;
    logic                  m_ready;
    t_pix                  m_data;
    logic                  m_last;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // model state
    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    t_pix             upper_mem [MAX_WIDTH];
    t_pix             middle_mem [MAX_WIDTH];
    t_win             win_q;
    int unsigned      col_pos;
    int unsigned      row_pos;

    t_median_exp pending_medians [$];
    int unsigned n_errors = 0;
    int unsigned items_sent = 0;
    bit          src_idle = 1'b1;
    bit          sink_idle = 1'b1;
    int          hold_len = 0;

    median_filter_3x3_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // [7:0] pixel
        .i_s_axis_tuser  (s_flush),  // [0] flush
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),   // [7:0] median
        .o_m_axis_tlast  (m_last),   // frame_end
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic int unsigned active_width(input logic [WID_W-1:0] v);
        if (v < MIN_WIDTH)
            return 32'(MIN_WIDTH);
        if (v > CAP_WIDTH)
            return 32'(CAP_WIDTH);
        return 32'(v);
    endfunction

    function automatic int unsigned active_height(input logic [HGT_W-1:0] v);
        return (v == '0) ? 32'd1 : 32'(v);
    endfunction

    // value with at most four smaller and at least five not larger
    function automatic t_pix median_of(input t_win v);
        int lt;
        int le;
        median_of = '0;
        for (int i = 0; i < WIN_SIZE; i++) begin
            lt = 0;
            le = 0;
            for (int j = 0; j < WIN_SIZE; j++) begin
                if (v[j] < v[i])
                    lt++;
                if (v[j] <= v[i])
                    le++;
            end
            if (lt <= 4 && le > 4)
                median_of = v[i];
        end
    endfunction

    task automatic reset_model();
        width_reg  = RESET_WIDTH;
        height_reg = RESET_HEIGHT;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_mem[i]  = '0;
            middle_mem[i] = '0;
        end
        win_q   = '0;
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        n_errors++;
    endtask

    // advance the filter model by one accepted item, queue the median it releases
    task automatic filter_item(input t_pix pix, input logic fl);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        t_pix        p;
        t_pix        top;
        t_pix        mid;
        t_win        shown;
        logic        last;
        t_median_exp m;
        w = active_width(width_reg);
        h = active_height(height_reg);
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        r = row_pos;
        c = col_pos;
        p   = (fl || r >= h) ? '0 : pix;
        top = (r >= 2) ? upper_mem[c] : '0;
        mid = (r >= 1) ? middle_mem[c] : '0;
        upper_mem[c]  = middle_mem[c];
        middle_mem[c] = p;
        for (int k = 0; k < 3; k++) begin
            win_q[k*3]   = win_q[k*3+1];
            win_q[k*3+1] = win_q[k*3+2];
            win_q[k*3+2] = '0;
        end
        // at a line start the median still belongs to the last pixel of the line above
        shown = win_q;
        if (c == 0) begin
            for (int k = 0; k < 3; k++) begin
                win_q[k*3]   = '0;
                win_q[k*3+1] = '0;
            end
        end
        win_q[2] = top;
        win_q[5] = mid;
        win_q[8] = p;
        if (c != 0)
            shown = win_q;
        last = (r >= h + 1) && (c == 0);
        if (last) begin
            row_pos = 0;
            col_pos = 0;
        end else begin
            col_pos = c + 1;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos = r + 1;
            end
        end
        if (r >= 2 || (r == 1 && c >= 1)) begin
            m.median    = median_of(shown);
            m.frame_end = last;
            pending_medians.push_back(m);
        end
    endtask

    task automatic write_reg(input logic reg_idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_FRAME_WIDTH)
            width_reg = value[WID_W-1:0];
        else
            height_reg = value[HGT_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic set_frame(input int unsigned wv, input int unsigned hv);
        logic [APB_DATA_W-1:0] junk;
        // bits above the field carry no meaning
        junk = ($urandom_range(0, 1) != 0) ? $urandom() : '0;
        write_reg(REG_FRAME_WIDTH, {junk[APB_DATA_W-1:WID_W], wv[WID_W-1:0]});
        junk = ($urandom_range(0, 1) != 0) ? $urandom() : '0;
        write_reg(REG_FRAME_HEIGHT, {junk[APB_DATA_W-1:HGT_W], hv[HGT_W-1:0]});
    endtask

    task automatic send_item(input t_pix pix, input logic fl);
        int gap;
        gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= pix;
        s_flush <= fl;
        do begin
            @(posedge i_clk);
        end while (!s_ready);
        filter_item(pix, fl);
        items_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_medians.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one whole frame: pixels, then width+1 flush items; noise swaps the kind of a few
    task automatic run_frame(input int unsigned wv, input int unsigned hv, input bit noisy,
                             input int pause_at);
        int   n_pix;
        int   n_all;
        int   style;
        t_pix base;
        t_pix pix;
        logic fl;
        set_frame(wv, hv);
        n_pix = active_width(width_reg) * active_height(height_reg);
        n_all = n_pix + active_width(width_reg) + 1;
        style = $urandom_range(0, 2);
        base  = t_pix'($urandom_range(0, 255));
        for (int i = 0; i < n_all; i++) begin
            case (style)
                0: pix = t_pix'($urandom_range(0, 255));
                1: pix = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                default: pix = ($urandom_range(0, 3) == 0) ? t_pix'($urandom_range(0, 255)) : base;
            endcase
            if (i < n_pix)
                fl = noisy && ($urandom_range(0, 31) == 0);
            else
                fl = !(noisy && ($urandom_range(0, 7) == 0));
            if (i == pause_at)
                drain_results();
            send_item(pix, fl);
        end
        drain_results();
    endtask

    task automatic test_directed();
        // width below the minimum, height zero: smallest frame
        set_frame(0, 0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hA5, 1'b1);
        send_item(8'hFF, 1'b0);    // pixel in the flush phase acts as flush
        send_item(8'h5A, 1'b1);
        send_item(8'h00, 1'b1);
        drain_results();
        // early flush stands in for a zero pixel
        set_frame(3, 2);
        repeat (4) send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'hFF, 1'b0);
        repeat (4) send_item(8'h00, 1'b1);
        drain_results();
        set_frame(2, 1);
        send_item(8'h00, 1'b0);
        send_item(8'h7F, 1'b0);
        send_item(8'h80, 1'b0);
        repeat (4) send_item(8'hFF, 1'b1);
        drain_results();
    endtask

    task automatic test_backpressure();
        src_idle  = 1'b0;
        sink_idle = 1'b1;
        hold_len  = LONG_HOLD;
        run_frame(16, 12, 1'b0, 150);
        src_idle = 1'b1;
    endtask

    task automatic test_size_extremes();
        // wide single line
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        run_frame(96, 1, 1'b0, -1);
        // narrow tall frame at full rate
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        run_frame(3, 48, 1'b1, -1);
    endtask

    task automatic test_random();
        int unsigned start;
        int unsigned wv;
        int unsigned hv;
        int          sel;
        int          pause_at;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
                wv = $urandom_range(0, 2);
            else if (sel < 4)
                wv = $urandom_range(13, 64);
            else
                wv = $urandom_range(3, 12);
            hv = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 10);
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            pause_at  = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 20)) : -1;
            run_frame(wv, hv, $urandom_range(0, 3) != 0, pause_at);
        end
    endtask

    // output side: random stalls per transaction, long hold on request
    initial begin : result_sink
        int gap;
        forever begin
            if (hold_len > 0) begin
                m_ready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
            end
            gap = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (!(m_valid && m_ready));
        end
    end

    always @(posedge i_clk) begin : check_medians
        t_median_exp want;
        if (i_rst_n && m_valid && m_ready) begin
            if (pending_medians.size() == 0) begin
                report_mismatch($sformatf("median %0d with none pending", m_data));
            end else begin
                want = pending_medians.pop_front();
                if (m_data !== want.median)
                    report_mismatch($sformatf("median %0d, model %0d", m_data, want.median));
                if (m_last !== want.frame_end)
                    report_mismatch($sformatf("frame_end %b, model %b", m_last, want.frame_end));
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("median_filter_3x3_unit: mismatch");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        s_flush <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        reset_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_size_extremes();
        test_random();
        drain_results();
        if (n_errors == 0)
            $display("median_filter_3x3_unit: match");
        else
            $display("median_filter_3x3_unit: mismatch");
        $finish;
    end

endmodule

### median_filter_3x3_unit.f
rtl/mf3_pkg.sv
rtl/mf3_line_store.sv
rtl/mf3_median.sv
rtl/median_filter_3x3_unit.sv
tb/sv/tb.sv
